// ----- rtl/ubod_pkg.sv -----
// ----------------------------------------------------------------------------
// ubod_pkg - shared types and constants
// Scan limit, derived widths, the queue entry passed from the front end to
// the scoring back end, and the codes for how the byte order was decided.
// ----------------------------------------------------------------------------
package ubod_pkg;

    localparam int SCAN_LIMIT = 400;
    localparam int POS_W      = $clog2(SCAN_LIMIT + 1);
    localparam int CNT_W      = $clog2(SCAN_LIMIT / 4 + 1);
    localparam int Q_DEPTH    = 4;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PLANE_MAX = 8'h10;
    localparam logic [7:0] BOM_HI    = 8'hFF;
    localparam logic [7:0] BOM_LO    = 8'hFE;

    typedef enum logic [1:0] {
        DEC_BOM     = 2'd0,
        DEC_SCORE   = 2'd1,
        DEC_DEFAULT = 2'd2
    } t_decided_by;

    // one entry per accepted byte
    typedef struct packed {
        logic inv_be;
        logic inv_le;
        logic p0_be;
        logic p0_le;
        logic last;
        logic bom_le;
        logic bom_be;
    } t_entry;

endpackage

// ----- rtl/ubod_if.sv -----
// ----------------------------------------------------------------------------
// ubod_if - stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ubod_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ubod_out_if;
    logic       valid;
    logic       ready;
    logic       big_endian;
    logic [1:0] decided_by;

    modport source (output valid, big_endian, decided_by, input ready);
    modport sink   (input valid, big_endian, decided_by, output ready);
endinterface

// ----- rtl/ubod_front.sv -----
// ----------------------------------------------------------------------------
// ubod_front - byte intake and word classification
// Tracks the byte position, assembles 4-byte words, flags each whole word
// for both byte orders and follows the byte order mark over the lead bytes.
// ----------------------------------------------------------------------------
module ubod_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ubod_in_if.sink           i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output ubod_pkg::t_entry  o_entry
);
    import ubod_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_word [3];
    logic             r_le_ok, n_le_ok;
    logic             r_be_ok, n_be_ok;
    logic             w_in_scan;
    logic [1:0]       w_lane;
    logic             w_word_done;
    logic [7:0]       w_le_pat, w_be_pat;
    logic [7:0]       b0, b1, b2, b3;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && i_in.ready;

    assign w_in_scan   = r_pos < POS_W'(SCAN_LIMIT);
    assign w_lane      = r_pos[1:0];
    assign w_word_done = w_in_scan && (w_lane == 2'd3);

    assign b0 = r_word[0];
    assign b1 = r_word[1];
    assign b2 = r_word[2];
    assign b3 = i_in.data_byte;

    // expected mark byte at this lane for either order
    always_comb begin
        case (w_lane)
            2'd0:    begin w_le_pat = BOM_HI; w_be_pat = 8'h00;  end
            2'd1:    begin w_le_pat = BOM_LO; w_be_pat = 8'h00;  end
            2'd2:    begin w_le_pat = 8'h00;  w_be_pat = BOM_LO; end
            default: begin w_le_pat = 8'h00;  w_be_pat = BOM_HI; end
        endcase
    end

    always_comb begin
        n_le_ok = r_le_ok;
        n_be_ok = r_be_ok;
        if (r_pos < POS_W'(4)) begin
            n_le_ok = r_le_ok && (i_in.data_byte == w_le_pat);
            n_be_ok = r_be_ok && (i_in.data_byte == w_be_pat);
        end
        n_pos = w_in_scan ? r_pos + POS_W'(1) : r_pos;
    end

    always_comb begin
        o_entry        = '0;
        o_entry.last   = i_in.last_byte;
        o_entry.bom_le = n_le_ok && (r_pos >= POS_W'(3));
        o_entry.bom_be = n_be_ok && (r_pos >= POS_W'(3));
        if (w_word_done) begin
            o_entry.inv_be = (b0 != 8'h00) || (b1 > PLANE_MAX);
            o_entry.inv_le = (b3 != 8'h00) || (b2 > PLANE_MAX);
            o_entry.p0_be  = (b0 == 8'h00) && (b1 == 8'h00) &&
                             ((b2 != 8'h00) || (b3 != 8'h00));
            o_entry.p0_le  = ((b0 != 8'h00) || (b1 != 8'h00)) &&
                             (b2 == 8'h00) && (b3 == 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_le_ok <= 1'b1;
            r_be_ok <= 1'b1;
        end else if (o_push) begin
            if (i_in.last_byte) begin
                // start a fresh buffer
                r_pos   <= '0;
                r_le_ok <= 1'b1;
                r_be_ok <= 1'b1;
            end else begin
                r_pos   <= n_pos;
                r_le_ok <= n_le_ok;
                r_be_ok <= n_be_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && w_in_scan && (w_lane != 2'd3)) begin
            r_word[w_lane] <= i_in.data_byte;
        end
    end

endmodule

// ----- rtl/ubod_queue.sv -----
// ----------------------------------------------------------------------------
// ubod_queue - classified word queue
// Small FIFO that decouples the front end from the scoring back end.
// ----------------------------------------------------------------------------
module ubod_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ubod_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output ubod_pkg::t_entry  o_entry,
    output logic              o_empty
);
    import ubod_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

// ----- rtl/ubod_back.sv -----
// ----------------------------------------------------------------------------
// ubod_back - scoring and decision
// Counts plane-zero and invalid words for both orders and, on the last
// entry of a buffer, loads the decision into the output register.
// ----------------------------------------------------------------------------
module ubod_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_default_be,
    input  logic              i_q_empty,
    input  ubod_pkg::t_entry  i_entry,
    output logic              o_pop,
    ubod_out_if.source        o_out
);
    import ubod_pkg::*;

    logic [CNT_W-1:0] r_inv_be, r_inv_le, r_p0_be, r_p0_le;
    logic [CNT_W-1:0] n_inv_be, n_inv_le, n_p0_be, n_p0_le;
    logic [CNT_W:0]   w_lhs, w_rhs;
    logic             r_valid;
    logic             r_big;
    t_decided_by      r_by;
    logic             n_big;
    t_decided_by      n_by;

    // hold a last entry until the output register is free
    assign o_pop = !i_q_empty && (!i_entry.last || !r_valid || o_out.ready);

    assign n_inv_be = r_inv_be + CNT_W'(i_entry.inv_be);
    assign n_inv_le = r_inv_le + CNT_W'(i_entry.inv_le);
    assign n_p0_be  = r_p0_be  + CNT_W'(i_entry.p0_be);
    assign n_p0_le  = r_p0_le  + CNT_W'(i_entry.p0_le);

    assign w_lhs = {1'b0, n_p0_be} + {1'b0, n_inv_le};
    assign w_rhs = {1'b0, n_p0_le} + {1'b0, n_inv_be};

    always_comb begin
        if (i_entry.bom_le) begin
            n_big = 1'b0;
            n_by  = DEC_BOM;
        end else if (i_entry.bom_be) begin
            n_big = 1'b1;
            n_by  = DEC_BOM;
        end else if (w_lhs > w_rhs) begin
            n_big = 1'b1;
            n_by  = DEC_SCORE;
        end else if (w_rhs > w_lhs) begin
            n_big = 1'b0;
            n_by  = DEC_SCORE;
        end else begin
            n_big = i_default_be;
            n_by  = DEC_DEFAULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_be <= '0;
            r_inv_le <= '0;
            r_p0_be  <= '0;
            r_p0_le  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_entry.last) begin
                    r_inv_be <= '0;
                    r_inv_le <= '0;
                    r_p0_be  <= '0;
                    r_p0_le  <= '0;
                end else begin
                    r_inv_be <= n_inv_be;
                    r_inv_le <= n_inv_le;
                    r_p0_be  <= n_p0_be;
                    r_p0_le  <= n_p0_le;
                end
            end
            if (o_pop && i_entry.last) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_big <= n_big;
            r_by  <= n_by;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.big_endian = r_big;
    assign o_out.decided_by = r_by;

endmodule

// ----- rtl/utf32_byte_order_detector.sv -----
// ----------------------------------------------------------------------------
// utf32_byte_order_detector - UTF-32 byte order detection
// Takes a buffer one byte at a time and gives one byte order decision on
// its last byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, back to back, across any number
// of buffers. The front end classifies each byte in the cycle it is taken
// and writes it to a four-entry queue; the back end drains one entry per
// cycle into the score counters. When the last entry is popped, the decision
// is loaded into the output register. A stalled result holds the back end on
// that buffer's last entry, and the byte input stalls only once the queue is
// full. The user must write the tie default only while no buffer is in flight;
// the block does not enforce this. It applies from the next result.
// ----------------------------------------------------------------------------
module utf32_byte_order_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    ubod_in_if.sink    i_in,
    ubod_out_if.source o_out
);
    import ubod_pkg::*;

    logic   r_default_be;
    logic   w_push, w_pop, w_full, w_empty;
    t_entry w_front_entry, w_back_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_be <= 1'b0;
        end else if (i_cfg_we) begin
            r_default_be <= i_cfg_wdata;
        end
    end

    ubod_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_front_entry)
    );

    ubod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_back_entry),
        .o_empty (w_empty)
    );

    ubod_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_default_be (r_default_be),
        .i_q_empty    (w_empty),
        .i_entry      (w_back_entry),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

    // a default decision carries the configured fallback
    a_default_matches_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.decided_by == DEC_DEFAULT)) |->
            (o_out.big_endian == r_default_be))
        else $error("default decision does not match configured fallback");

    a_decided_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.decided_by == DEC_BOM || o_out.decided_by == DEC_SCORE ||
                         o_out.decided_by == DEC_DEFAULT))
        else $error("result carries an unknown decision code");

    // a mark cannot be seen in both orders at once
    a_bom_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !(w_front_entry.bom_le && w_front_entry.bom_be))
        else $error("byte order mark matched both orders");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid straight after reset");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench for utf32_byte_order_detector
// Sends byte buffers through the input channel under random idling and
// back-pressure. A local model of the scoring predicts each byte order
// decision, and every decision that comes out is compared with it in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ubod_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic        big_endian;
        t_decided_by decided_by;
    } t_verdict;

    localparam int PHASE_BYTES = 620;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ubod_in_if  in_if ();
    ubod_out_if out_if ();

    utf32_byte_order_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_byte_item pending[$];
    t_verdict   expected_verdicts[$];

    int   tx_idle_pct = 18;
    int   rx_idle_pct = 51;
    int   phase       = 0;
    int   fail_count  = 0;
    logic rx_hold     = 1'b0;
    logic in_took     = 1'b0;

    // scoring model state
    logic             tie_big_endian = 1'b0;
    logic [POS_W-1:0] scan_pos;
    logic [7:0]       word_buf [3];
    logic [7:0]       lead_buf [4];
    logic [CNT_W-1:0] inv_le_cnt, inv_be_cnt, p0_le_cnt, p0_be_cnt;

    // {last, byte}: short buffer, both marks, a clear win each way, an
    // all-invalid tie and a three-byte buffer that looks like a mark
    logic [8:0] directed_seq [25] = '{
        9'h1FF,
        9'h0FF, 9'h0FE, 9'h000, 9'h100,
        9'h000, 9'h000, 9'h0FE, 9'h1FF,
        9'h000, 9'h000, 9'h000, 9'h041, 9'h100,
        9'h041, 9'h000, 9'h000, 9'h100,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h000, 9'h000, 9'h1FE
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic clear_scan();
        scan_pos   = '0;
        word_buf   = '{default: 8'h00};
        lead_buf   = '{default: 8'h00};
        inv_le_cnt = '0;
        inv_be_cnt = '0;
        p0_le_cnt  = '0;
        p0_be_cnt  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [1:0]     lane;
        logic [CNT_W:0] be_side, le_side;
        t_verdict       v;
        if (scan_pos < SCAN_LIMIT) begin
            lane = scan_pos[1:0];
            if (scan_pos < 4) lead_buf[lane] = b;
            if (lane == 2'd3) begin
                if (word_buf[0] != 8'h00 || word_buf[1] > PLANE_MAX)
                    inv_be_cnt = inv_be_cnt + CNT_W'(1);
                if (b != 8'h00 || word_buf[2] > PLANE_MAX)
                    inv_le_cnt = inv_le_cnt + CNT_W'(1);
                if (word_buf[0] == 8'h00 && word_buf[1] == 8'h00
                        && (word_buf[2] != 8'h00 || b != 8'h00))
                    p0_be_cnt = p0_be_cnt + CNT_W'(1);
                if ((word_buf[0] != 8'h00 || word_buf[1] != 8'h00)
                        && word_buf[2] == 8'h00 && b == 8'h00)
                    p0_le_cnt = p0_le_cnt + CNT_W'(1);
            end else begin
                word_buf[lane] = b;
            end
            scan_pos = scan_pos + POS_W'(1);
        end
        if (last) begin
            be_side = {1'b0, p0_be_cnt} + {1'b0, inv_le_cnt};
            le_side = {1'b0, p0_le_cnt} + {1'b0, inv_be_cnt};
            if (scan_pos >= 4 && lead_buf[0] == BOM_HI && lead_buf[1] == BOM_LO
                    && lead_buf[2] == 8'h00 && lead_buf[3] == 8'h00) begin
                v = '{1'b0, DEC_BOM};
            end else if (scan_pos >= 4 && lead_buf[0] == 8'h00 && lead_buf[1] == 8'h00
                    && lead_buf[2] == BOM_LO && lead_buf[3] == BOM_HI) begin
                v = '{1'b1, DEC_BOM};
            end else if (be_side > le_side) begin
                v = '{1'b1, DEC_SCORE};
            end else if (le_side > be_side) begin
                v = '{1'b0, DEC_SCORE};
            end else begin
                v = '{tie_big_endian, DEC_DEFAULT};
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 10) $display("%0t: %s", $realtime, msg);
        fail_count = fail_count + 1;
    endtask

    // model update and result check
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
            tie_big_endian = 1'b0;
            clear_scan();
        end else begin
            in_took <= in_if.valid && in_if.ready;
            if (i_cfg_we) tie_big_endian = i_cfg_wdata;
            if (in_if.valid && in_if.ready) absorb_byte(in_if.data_byte, in_if.last_byte);
            if (out_if.valid && out_if.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected decision be=%0b by=%0d",
                                              out_if.big_endian, out_if.decided_by));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (out_if.big_endian !== want.big_endian
                            || out_if.decided_by !== want.decided_by)
                        report_mismatch($sformatf(
                            "decision mismatch: expected be=%0b by=%0d, got be=%0b by=%0d",
                            want.big_endian, want.decided_by,
                            out_if.big_endian, out_if.decided_by));
                end
            end
        end
    end

    // present the next byte once the current one is taken
    always @(negedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= 8'h00;
            in_if.last_byte <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (in_took) pending.delete(0);
            if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_if.valid     <= 1'b1;
                in_if.data_byte <= pending[0].data;
                in_if.last_byte <= pending[0].last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver stall in the skewed phase so that the input backs up
    initial begin : rx_hold_off
        wait (phase == 2);
        repeat (60) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic queue_buffer(input logic force_long, output int len);
        logic [7:0]  buf_bytes [$];
        logic [7:0]  w [4];
        logic [31:0] cp;
        t_byte_item  item;
        int          pick, kind, k;
        logic        big;
        pick = $urandom_range(99);
        if (force_long || pick < 5)
            len = $urandom_range(SCAN_LIMIT + 40, SCAN_LIMIT - 20);
        else if (pick < 80)
            len = $urandom_range(24, 1);
        else
            len = $urandom_range(80, 25);
        kind = $urandom_range(5);
        big  = 1'($urandom_range(1));
        // mark first, intact or with one byte damaged
        if (kind <= 1) begin
            if (big) w = '{8'h00, 8'h00, BOM_LO, BOM_HI};
            else     w = '{BOM_HI, BOM_LO, 8'h00, 8'h00};
            if (kind == 1) w[$urandom_range(3)] = 8'($urandom_range(255));
            for (k = 0; k < 4; k++) buf_bytes.insert(buf_bytes.size(), w[k]);
        end
        while (buf_bytes.size() < len) begin
            if (kind == 5) begin
                buf_bytes.insert(buf_bytes.size(), 8'($urandom_range(255)));
            end else begin
                if (kind == 4) begin
                    // mirrored words score the same both ways
                    w[0] = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
                    w[1] = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
                    w[2] = w[1];
                    w[3] = w[0];
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 50)      cp = $urandom_range(32'hFFFF, 1);
                    else if (pick < 65) cp = $urandom_range(32'h10FFFF, 32'h10000);
                    else if (pick < 75) cp = 32'h0;
                    else if (pick < 85) cp = $urandom();
                    else cp = {8'h00, ($urandom_range(1) ? 8'h10 : 8'h11), 16'($urandom())};
                    if (kind == 3) big = 1'($urandom_range(1));
                    if (big) w = '{cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
                    else     w = '{cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
                end
                for (k = 0; k < 4; k++) buf_bytes.insert(buf_bytes.size(), w[k]);
            end
        end
        for (k = 0; k < len; k++) begin
            item.data = buf_bytes[k];
            item.last = (k == len - 1);
            pending.insert(pending.size(), item);
        end
    endtask

    task automatic wait_quiet();
        while (pending.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_tie_default(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic fill_random(input int target);
        int queued, n;
        queued = 0;
        queue_buffer(1'b1, n);
        queued = queued + n;
        while (queued < target) begin
            queue_buffer(1'b0, n);
            queued = queued + n;
        end
    endtask

    initial begin : stimulus
        t_byte_item item;
        int         i;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_tie_default(1'b1);
        for (i = 0; i < 25; i++) begin
            item.data = directed_seq[i][7:0];
            item.last = directed_seq[i][8];
            pending.insert(pending.size(), item);
        end
        phase = 1;
        wait_quiet();

        write_tie_default(1'b0);
        fill_random(PHASE_BYTES);
        wait_quiet();

        write_tie_default(1'b1);
        tx_idle_pct = 51;
        rx_idle_pct = 18;
        phase = 2;
        fill_random(PHASE_BYTES);
        wait_quiet();

        // no idling; hold the sender mid-phase until every decision is out
        write_tie_default(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase = 3;
        fill_random(PHASE_BYTES / 2);
        wait_quiet();
        fill_random(PHASE_BYTES / 2);
        wait_quiet();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
